// ----- src/tmp_pkg.sv -----
// Shared widths, codes and constants for the trapezoid motion profile block.
`default_nettype none
package tmp_pkg;

    // Fixed point layout of positions and times
    localparam int POS_W  = 32;
    localparam int FRAC_W = 16;
    localparam int REG_W  = 31;
    localparam int TIME_W = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_MAX_VEL   = 2'd1;
    localparam logic [1:0] CFG_MAX_ACC   = 2'd2;
    localparam logic [1:0] CFG_INIT_POS  = 2'd3;

    // Register reset values
    localparam logic [REG_W-1:0] TIME_STEP_RST = 31'd3277;
    localparam logic [REG_W-1:0] MAX_VEL_RST   = 31'd131072;
    localparam logic [REG_W-1:0] MAX_ACC_RST   = 31'd32768;

    // Retarget threshold: round(0.01 in Q format)
    localparam int RETARGET_THR = ((1 << FRAC_W) + 50) / 100;

    // Direction of the current move
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_ZERO = 2'd0;
    localparam t_dir DIR_POS  = 2'd1;
    localparam t_dir DIR_NEG  = 2'd2;

endpackage
`default_nettype wire

// ----- src/trapezoid_motion_profile.sv -----
// Top level of the trapezoid motion profile generator: sequencer, shared multiplier,
// bit-serial divider and bit-serial square root.
`default_nettype none
// Each accepted target gives one setpoint. A tick that does not retarget skips the
// multiplier at rest or once the move is done; otherwise the profile math runs through
// the 32x32 multiplier in sequence, up to seven times for a triangle brake. A tick that
// starts a new move first runs three restoring divisions of 32 or 33 steps on the one
// divider; a triangle move adds a 32 step square root and a fourth division. Input is
// taken only while the sequencer is idle; a finished setpoint waits in the output
// register and does not block the next transfer in, but the following setpoint waits in
// the sequencer until that register is free.
module trapezoid_motion_profile
    import tmp_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [1:0]               i_cfg_idx,
    input  wire logic [POS_W-1:0]         i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic signed [POS_W-1:0]  i_target_position,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic signed [POS_W-1:0]       o_setpoint
);

    // Sequencer codes
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_CHECK   = 5'd1;
    localparam logic [4:0] ST_MV_VV   = 5'd2;
    localparam logic [4:0] ST_MV_DACC = 5'd3;
    localparam logic [4:0] ST_MV_DAE  = 5'd4;
    localparam logic [4:0] ST_MV_DDS  = 5'd5;
    localparam logic [4:0] ST_MV_END  = 5'd6;
    localparam logic [4:0] ST_MV_MA   = 5'd7;
    localparam logic [4:0] ST_MV_SQ   = 5'd8;
    localparam logic [4:0] ST_SQ_RUN  = 5'd9;
    localparam logic [4:0] ST_MV_DTP  = 5'd10;
    localparam logic [4:0] ST_MV_TPT  = 5'd11;
    localparam logic [4:0] ST_DIV_RUN = 5'd12;
    localparam logic [4:0] ST_ADV     = 5'd13;
    localparam logic [4:0] ST_PROF    = 5'd14;
    localparam logic [4:0] ST_H_MA    = 5'd15;
    localparam logic [4:0] ST_H_MB    = 5'd16;
    localparam logic [4:0] ST_H_MC    = 5'd17;
    localparam logic [4:0] ST_H_MD    = 5'd18;
    localparam logic [4:0] ST_L_M     = 5'd19;
    localparam logic [4:0] ST_PF_A    = 5'd20;
    localparam logic [4:0] ST_PF_B    = 5'd21;
    localparam logic [4:0] ST_PF_C    = 5'd22;
    localparam logic [4:0] ST_PF_D1   = 5'd23;
    localparam logic [4:0] ST_PF_D2   = 5'd24;
    localparam logic [4:0] ST_OUT     = 5'd25;

    localparam logic [63:0] MAG_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [32:0] ACC_CAP  = 33'h1_0000_0000;
    localparam logic [31:0] THR      = 32'(RETARGET_THR);

    // Control and profile state
    logic [4:0]              r_state, r_ret, r_hret;
    logic [REG_W-1:0]        r_ts, r_v, r_a;
    logic signed [POS_W-1:0] r_move_start, r_held, r_cmd;
    logic [POS_W-1:0]        r_mag;
    t_dir                    r_dir;
    logic [TIME_W-1:0]       r_elapsed, r_ae, r_ds, r_me, r_tpt;
    logic [REG_W-1:0]        r_tpv;
    logic [32:0]             r_acc;
    logic                    r_trap;
    // Datapath registers
    logic [63:0]             r_prod, r_pp;
    logic [TIME_W-1:0]       r_x;
    logic [61:0]             r_h;
    logic [62:0]             r_base, r_p;
    // Divider
    logic [REG_W-1:0]        r_rem, r_dsr;
    logic [32:0]             r_num, r_quo;
    logic                    r_ovf;
    logic [5:0]              r_cnt;
    // Square root
    logic [63:0]             r_sn, r_sres, r_sbit;
    // Output register
    logic                    r_out_valid;
    logic signed [POS_W-1:0] r_setpoint;

    // Effective limits: zero counts as one LSB
    logic [REG_W-1:0] v_e, a_e;
    assign v_e = (r_v == '0) ? REG_W'(1) : r_v;
    assign a_e = (r_a == '0) ? REG_W'(1) : r_a;

    // Shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_out;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MV_VV: begin
                mul_a = {1'b0, v_e};
                mul_b = {1'b0, v_e};
            end
            ST_MV_MA: begin
                mul_a = r_mag;
                mul_b = {1'b0, a_e};
            end
            ST_H_MA: begin
                mul_a = {1'b0, a_e};
                mul_b = r_x;
            end
            ST_H_MB: begin
                mul_a = r_prod[47:16];
                mul_b = r_x;
            end
            ST_H_MC: begin
                mul_a = {17'b0, r_prod[62:48]};
                mul_b = r_x;
            end
            ST_L_M: begin
                mul_a = {1'b0, (r_trap ? v_e : r_tpv)};
                mul_b = r_x;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_out = 64'(mul_a) * 64'(mul_b);

    // Fraction divide operands: (num << FRAC) / den
    logic [31:0]      qd_num;
    logic [REG_W-1:0] qd_den;
    always_comb begin
        unique case (r_state)
            ST_MV_DAE: begin
                qd_num = {1'b0, v_e};
                qd_den = a_e;
            end
            ST_MV_DDS: begin
                qd_num = r_mag;
                qd_den = v_e;
            end
            default: begin
                qd_num = r_sres[31:0];
                qd_den = a_e;
            end
        endcase
    end

    // Divider step
    logic [31:0] div_t;
    logic        div_ge;
    logic [31:0] div_sub;
    assign div_t   = {r_rem, r_num[32]};
    assign div_ge  = div_t >= {1'b0, r_dsr};
    assign div_sub = div_t - {1'b0, r_dsr};
    logic [TIME_W-1:0] qd_res;
    assign qd_res = r_ovf ? '1 : r_quo[31:0];

    // Square root step
    logic [63:0] sq_try;
    assign sq_try = r_sres + r_sbit;

    // Retarget check
    logic signed [POS_W:0] diff;
    logic [POS_W:0]        adiff;
    assign diff  = {r_cmd[POS_W-1], r_cmd} - {r_held[POS_W-1], r_held};
    assign adiff = diff[POS_W] ? (POS_W+1)'(-diff) : diff;

    // Elapsed time advance with saturation
    logic [TIME_W:0] el_sum;
    assign el_sum = {1'b0, r_elapsed} + {2'b0, r_ts};

    // Profile end points
    logic [TIME_W-1:0] ds_val;
    logic [TIME_W:0]   me_sum;
    assign ds_val = qd_res;
    assign me_sum = {1'b0, r_ae} + {1'b0, ds_val};

    // Half a t squared: combine the two partial products
    logic [63:0] h_sum, h_cap;
    assign h_sum = {r_prod[47:0], 16'b0} + {16'b0, r_pp[63:16]};
    assign h_cap = (h_sum > MAG_CAP) ? MAG_CAP : h_sum;

    logic [62:0] lin_sum;
    assign lin_sum = {30'b0, r_acc} + {16'b0, r_prod[62:16]};

    // Clamp and place the setpoint
    logic [POS_W-1:0] p_c;
    assign p_c = (r_p > {31'b0, r_mag}) ? r_mag : r_p[POS_W-1:0];

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_setpoint  = r_setpoint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ret        <= ST_IDLE;
            r_hret       <= ST_IDLE;
            r_ts         <= TIME_STEP_RST;
            r_v          <= MAX_VEL_RST;
            r_a          <= MAX_ACC_RST;
            r_move_start <= '0;
            r_held       <= '0;
            r_mag        <= '0;
            r_dir        <= DIR_ZERO;
            r_elapsed    <= '0;
            r_trap       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            // Drop the result once the consumer takes it, unless a new one loads
            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_target_position;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    if (adiff > {1'b0, THR}) begin
                        r_move_start <= r_held;
                        r_held       <= r_cmd;
                        r_mag        <= adiff[POS_W-1:0];
                        r_dir        <= diff[POS_W] ? DIR_NEG : DIR_POS;
                        r_elapsed    <= '0;
                        r_state      <= ST_MV_VV;
                    end else begin
                        r_state <= ST_ADV;
                    end
                end
                ST_MV_VV: begin
                    r_prod  <= mul_out;
                    r_state <= ST_MV_DACC;
                end
                ST_MV_DACC: begin
                    // Acceleration distance: v*v / (2a), capped
                    r_ovf   <= r_prod[63:33] >= a_e;
                    r_rem   <= r_prod[63:33];
                    r_num   <= r_prod[32:0];
                    r_dsr   <= a_e;
                    r_quo   <= '0;
                    r_cnt   <= 6'd33;
                    r_ret   <= ST_MV_DAE;
                    r_state <= ST_DIV_RUN;
                end
                ST_MV_DAE: begin
                    r_acc   <= r_ovf ? ACC_CAP : {1'b0, r_quo[32:1]};
                    r_ovf   <= {15'b0, qd_num[31:16]} >= qd_den;
                    r_rem   <= {15'b0, qd_num[31:16]};
                    r_num   <= {qd_num[15:0], 17'b0};
                    r_dsr   <= qd_den;
                    r_quo   <= '0;
                    r_cnt   <= 6'd32;
                    r_ret   <= ST_MV_DDS;
                    r_state <= ST_DIV_RUN;
                end
                ST_MV_DDS: begin
                    r_ae    <= qd_res;
                    r_ovf   <= {15'b0, qd_num[31:16]} >= qd_den;
                    r_rem   <= {15'b0, qd_num[31:16]};
                    r_num   <= {qd_num[15:0], 17'b0};
                    r_dsr   <= qd_den;
                    r_quo   <= '0;
                    r_cnt   <= 6'd32;
                    r_ret   <= ST_MV_END;
                    r_state <= ST_DIV_RUN;
                end
                ST_MV_END: begin
                    r_ds <= ds_val;
                    r_me <= me_sum[TIME_W] ? '1 : me_sum[TIME_W-1:0];
                    if ({2'b0, r_mag} > {r_acc, 1'b0}) begin
                        r_trap  <= 1'b1;
                        r_tpt   <= '0;
                        r_tpv   <= '0;
                        r_state <= ST_ADV;
                    end else begin
                        r_trap  <= 1'b0;
                        r_state <= ST_MV_MA;
                    end
                end
                ST_MV_MA: begin
                    r_prod  <= mul_out;
                    r_state <= ST_MV_SQ;
                end
                ST_MV_SQ: begin
                    r_sn    <= r_prod;
                    r_sres  <= '0;
                    r_sbit  <= MAG_CAP;
                    r_cnt   <= 6'd32;
                    r_state <= ST_SQ_RUN;
                end
                ST_SQ_RUN: begin
                    if (r_sn >= sq_try) begin
                        r_sn   <= r_sn - sq_try;
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= ST_MV_DTP;
                    end
                end
                ST_MV_DTP: begin
                    r_tpv   <= r_sres[REG_W-1:0];
                    r_ovf   <= {15'b0, qd_num[31:16]} >= qd_den;
                    r_rem   <= {15'b0, qd_num[31:16]};
                    r_num   <= {qd_num[15:0], 17'b0};
                    r_dsr   <= qd_den;
                    r_quo   <= '0;
                    r_cnt   <= 6'd32;
                    r_ret   <= ST_MV_TPT;
                    r_state <= ST_DIV_RUN;
                end
                ST_MV_TPT: begin
                    r_tpt   <= qd_res;
                    r_state <= ST_ADV;
                end
                ST_DIV_RUN: begin
                    // One quotient bit per cycle
                    r_rem <= div_ge ? div_sub[REG_W-1:0] : div_t[REG_W-1:0];
                    r_quo <= {r_quo[31:0], div_ge};
                    r_num <= {r_num[31:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= r_ret;
                    end
                end
                ST_ADV: begin
                    r_elapsed <= el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
                    r_state   <= ST_PROF;
                end
                ST_PROF: begin
                    // Pick the phase
                    if (r_dir == DIR_ZERO) begin
                        r_p     <= '0;
                        r_state <= ST_OUT;
                    end else if (r_trap) begin
                        if (r_elapsed < r_ae) begin
                            r_x     <= r_elapsed;
                            r_hret  <= ST_PF_A;
                            r_state <= ST_H_MA;
                        end else if (r_elapsed < r_me) begin
                            r_x     <= r_elapsed - r_ae;
                            r_state <= ST_L_M;
                        end else begin
                            r_p     <= {31'b0, r_mag};
                            r_state <= ST_OUT;
                        end
                    end else begin
                        if (r_elapsed < r_tpt) begin
                            r_x     <= r_elapsed;
                            r_hret  <= ST_PF_A;
                            r_state <= ST_H_MA;
                        end else if ({1'b0, r_elapsed} <= {r_tpt, 1'b0}) begin
                            r_x     <= r_tpt;
                            r_hret  <= ST_PF_D1;
                            r_state <= ST_H_MA;
                        end else begin
                            r_p     <= {31'b0, r_mag};
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_H_MA: begin
                    r_prod  <= mul_out;
                    r_state <= ST_H_MB;
                end
                ST_H_MB: begin
                    r_pp    <= mul_out;
                    r_state <= ST_H_MC;
                end
                ST_H_MC: begin
                    r_prod  <= mul_out;
                    r_state <= ST_H_MD;
                end
                ST_H_MD: begin
                    r_h     <= h_cap[62:1];
                    r_state <= r_hret;
                end
                ST_L_M: begin
                    r_prod  <= mul_out;
                    r_state <= r_trap ? ST_PF_B : ST_PF_D2;
                end
                ST_PF_A: begin
                    r_p     <= {1'b0, r_h};
                    r_state <= ST_OUT;
                end
                ST_PF_B: begin
                    // Cruise, then brake past the decel point
                    if (r_elapsed < r_ds) begin
                        r_p     <= lin_sum;
                        r_state <= ST_OUT;
                    end else begin
                        r_base  <= lin_sum;
                        r_x     <= r_elapsed - r_ds;
                        r_hret  <= ST_PF_C;
                        r_state <= ST_H_MA;
                    end
                end
                ST_PF_C: begin
                    r_p     <= (r_base > {1'b0, r_h}) ? r_base - {1'b0, r_h} : '0;
                    r_state <= ST_OUT;
                end
                ST_PF_D1: begin
                    r_base  <= {1'b0, r_h};
                    r_x     <= r_elapsed - r_tpt;
                    r_state <= ST_L_M;
                end
                ST_PF_D2: begin
                    r_base  <= r_base + {16'b0, r_prod[62:16]};
                    r_hret  <= ST_PF_C;
                    r_state <= ST_H_MA;
                end
                ST_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        unique case (r_dir)
                            DIR_POS: r_setpoint <= r_move_start + $signed(p_c);
                            DIR_NEG: r_setpoint <= r_move_start - $signed(p_c);
                            default: r_setpoint <= r_move_start;
                        endcase
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TIME_STEP: r_ts <= i_cfg_data[REG_W-1:0];
                    CFG_MAX_VEL:   r_v  <= i_cfg_data[REG_W-1:0];
                    CFG_MAX_ACC:   r_a  <= i_cfg_data[REG_W-1:0];
                    CFG_INIT_POS: begin
                        r_move_start <= i_cfg_data;
                        r_held       <= i_cfg_data;
                        r_mag        <= '0;
                        r_dir        <= DIR_ZERO;
                        r_elapsed    <= '0;
                    end
                    default: begin
                        r_ts <= r_ts;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire
